// File: design/ssi_pkg.sv
// ----------------------------------------------------------------------------
// Sorted symbol insert package
// Shared types and constants for the sorted symbol insert unit and its cells.
// ----------------------------------------------------------------------------
package ssi_pkg;

   localparam int SYM_W = 8;

   typedef logic [SYM_W-1:0] sym_type;

   typedef struct packed {
      logic ins;       // insert the request symbol this cycle
      logic rot;       // rotate the occupied row one place toward cell zero
      logic occupied;  // cell holds a stored symbol
      logic open;      // cell is the first free cell
      logic tail;      // cell holds the last stored symbol
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

// File: design/sorted_symbol_insert_unit.sv
// ----------------------------------------------------------------------------
// Sorted symbol insert unit
// Ascending sorted store of byte symbols held in a row of cells.
// ----------------------------------------------------------------------------
// A symbol is taken when start is high and busy is low. In that same edge it
// is placed in the row before the first stored symbol greater than it, or
// dropped if the store already holds CAPACITY symbols. Busy then stays high
// while the whole store is sent out in ascending order, one beat per cycle on
// rsp_valid, with rsp_last on the final beat and rsp_dropped_full on every
// beat of a run whose symbol was dropped. The row rotates one place per cycle
// out through cell zero to send the beats, and no new symbol is taken until the
// run ends. The receiver cannot stall the beats.
module sorted_symbol_insert_unit #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   output logic [7:0] rsp_value,
   output logic       rsp_last,
   output logic       rsp_dropped_full
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   ssi_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               full_ff, full_in;

   ssi_pkg::sym_type   cell_value [CAPACITY];
   logic               cell_gt    [CAPACITY];

   logic accept;
   logic full_now;
   logic last_beat;

   assign accept    = start && !busy;
   assign full_now  = (count_ff == CAP_CNT);
   assign last_beat = (idx_ff == count_ff - ONE_CNT);

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         ssi_pkg::ctl_type ctl;
         ssi_pkg::sym_type prev_value;
         ssi_pkg::sym_type next_value;
         logic             prev_gt;

         assign ctl.ins      = accept && !full_now;
         assign ctl.rot      = (state_ff == ssi_pkg::ST_EMIT);
         assign ctl.occupied = (CW'(gi) < count_ff);
         assign ctl.open     = (CW'(gi) == count_ff);
         assign ctl.tail     = (CW'(gi) == count_ff - ONE_CNT);

         if (gi == 0) begin : g_first
            assign prev_value = cell_value[0];
            assign prev_gt    = 1'b0;
         end else begin : g_rest
            assign prev_value = cell_value[gi-1];
            assign prev_gt    = cell_gt[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_end
            assign next_value = cell_value[gi];
         end else begin : g_mid
            assign next_value = cell_value[gi+1];
         end

         ssi_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .symbol     (req_symbol),
            .prev_value (prev_value),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .head_value (cell_value[0]),
            .value      (cell_value[gi]),
            .gt         (cell_gt[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      full_in  = full_ff;
      case (state_ff)
         ssi_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ssi_pkg::ST_EMIT;
               idx_in   = '0;
               full_in  = full_now;
               if (!full_now) begin
                  count_in = count_ff + ONE_CNT;
               end
            end
         end
         ssi_pkg::ST_EMIT: begin
            idx_in = idx_ff + ONE_CNT;
            if (last_beat) begin
               state_in = ssi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssi_pkg::ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         full_ff  <= full_in;
      end
   end

   assign busy             = (state_ff != ssi_pkg::ST_IDLE);
   assign rsp_valid        = (state_ff == ssi_pkg::ST_EMIT);
   assign rsp_value        = cell_value[0];
   assign rsp_last         = rsp_valid && last_beat;
   assign rsp_dropped_full = full_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("Entry count exceeds capacity.");

   a_beat_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < count_ff))
      else $error("Beat index beyond the stored entries.");

   a_accept_starts_run : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid && idx_ff == '0 && count_ff != '0))
      else $error("Accepted symbol did not start a run of beats.");

   a_last_ends_run : assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !busy)
      else $error("Run continued after its last beat.");

   a_drop_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (accept && full_now) |=> (count_ff == CAP_CNT && full_ff))
      else $error("Dropped symbol changed the store.");

endmodule

// File: design/ssi_cell.sv
// ----------------------------------------------------------------------------
// Sorted symbol insert cell
// One entry of the sorted row: makes room for a new symbol and takes part in
// the rotation that walks the row out through cell zero.
// ----------------------------------------------------------------------------
module ssi_cell (
   input  logic             clock,
   input  ssi_pkg::ctl_type ctl,
   input  ssi_pkg::sym_type symbol,
   input  ssi_pkg::sym_type prev_value,
   input  logic             prev_gt,
   input  ssi_pkg::sym_type next_value,
   input  ssi_pkg::sym_type head_value,
   output ssi_pkg::sym_type value,
   output logic             gt
);

   ssi_pkg::sym_type value_ff;
   ssi_pkg::sym_type value_in;

   assign gt    = ctl.occupied && (value_ff > symbol);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins && (gt || ctl.open)) begin
         value_in = prev_gt ? prev_value : symbol;
      end else if (ctl.rot && ctl.occupied) begin
         value_in = ctl.tail ? head_value : next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: sim/sorted_symbol_insert_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted symbol insert unit testbench
// Sends byte symbols into the unit and checks every beat of each sorted run.
// ----------------------------------------------------------------------------
// A directed sequence fills the store with extreme, repeated and alternating
// bit patterns, then overflows it. Random symbols follow. The expected runs
// come from a behavioral copy of the sorted store that is kept in step with
// every accepted symbol. The request side idles at random between symbols.
module sorted_symbol_insert_unit_tb;

   localparam int STORE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 200;
   localparam int IDLE_LIMIT = 1000;
   localparam int TAIL_CYCLES = 2 * STORE_DEPTH + 4;

   typedef struct packed {
      ssi_pkg::sym_type value;
      logic             last;
      logic             dropped_full;
   } beat_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ssi_pkg::sym_type req_symbol = '0;
   logic             rsp_valid;
   ssi_pkg::sym_type rsp_value;
   logic             rsp_last;
   logic             rsp_dropped_full;

   ssi_pkg::sym_type symbol_queue[$];
   beat_type         expected_beats[$];
   ssi_pkg::sym_type stored_syms[STORE_DEPTH];
   int unsigned      stored_count = 0;

   int       items_loaded = 0;
   int       accepted_count = 0;
   int       mismatch_count = 0;
   int       idle_cycles = 0;
   int       gap_left = 0;
   int       steady_left = 0;
   int       next_gap;
   int       gap_roll;
   beat_type want;

   sorted_symbol_insert_unit #(
      .CAPACITY(STORE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_symbol(req_symbol),
      .rsp_valid(rsp_valid),
      .rsp_value(rsp_value),
      .rsp_last(rsp_last),
      .rsp_dropped_full(rsp_dropped_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic insert_and_list(input ssi_pkg::sym_type sym);
      int unsigned slot;
      logic        full;
      beat_type    b;
      full = (stored_count >= STORE_DEPTH);
      if (!full) begin
         slot = 0;
         while (slot < stored_count && stored_syms[slot] <= sym) slot++;
         for (int j = stored_count; j > slot; j--) stored_syms[j] = stored_syms[j-1];
         stored_syms[slot] = sym;
         stored_count++;
      end
      for (int k = 0; k < stored_count; k++) begin
         b.value = stored_syms[k];
         b.last = (k + 1 == stored_count);
         b.dropped_full = full;
         expected_beats.push_back(b);
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         insert_and_list(req_symbol);
         accepted_count++;
         gap_roll = $urandom_range(0, 99);
         if (steady_left != 0) begin
            steady_left--;
            next_gap = 0;
         end else if (gap_roll < 5) begin
            steady_left = $urandom_range(8, 20);
            next_gap = 0;
         end else if (gap_roll < 40) begin
            next_gap = 0;
         end else if (gap_roll < 75) begin
            next_gap = $urandom_range(1, 3);
         end else begin
            next_gap = $urandom_range(4, 40);
         end
         if (next_gap == 0 && symbol_queue.size() != 0) begin
            req_symbol <= symbol_queue.pop_front();
         end else begin
            start <= 1'b0;
            gap_left <= (next_gap == 0) ? 0 : next_gap - 1;
         end
      end else if (!start) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (symbol_queue.size() != 0) begin
            start <= 1'b1;
            req_symbol <= symbol_queue.pop_front();
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_beats.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected beat: value %02h last %0b dropped_full %0b",
                        rsp_value, rsp_last, rsp_dropped_full);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_value !== want.value || rsp_last !== want.last ||
                rsp_dropped_full !== want.dropped_full) begin
               if (mismatch_count < 10)
                  $display({"beat mismatch: expected value %02h last %0b ",
                            "dropped_full %0b, got value %02h last %0b ",
                            "dropped_full %0b"},
                           want.value, want.last, want.dropped_full,
                           rsp_value, rsp_last, rsp_dropped_full);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sorted_symbol_insert_unit_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      // The first sixteen symbols fill the store; the rest overflow it.
      symbol_queue = '{8'h80, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h55, 8'hAA,
                       8'h7F, 8'h01, 8'hFE, 8'h40, 8'h20, 8'h10, 8'h08, 8'h80,
                       8'h00, 8'hFF, 8'h80};
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            symbol_queue.push_back(8'h00);
         else if (r == 1)
            symbol_queue.push_back(8'hFF);
         else
            symbol_queue.push_back(ssi_pkg::sym_type'($urandom_range(0, 255)));
      end
      items_loaded = symbol_queue.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count != items_loaded || expected_beats.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("sorted_symbol_insert_unit_tb passed");
      end else begin
         $display("sorted_symbol_insert_unit_tb failed");
      end
      $finish;
   end

endmodule
